// ===== rtl/core/clpa_pkg.sv =====
// Shared constants, codes and types for the CGA and linear pixel access unit.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`default_nettype none

package clpa_pkg;

    // Store geometry: addresses are formed over 16 bits, then index the store.
    localparam int STORE_ADDR_BITS = 16;
    localparam int STORE_DEPTH     = 1 << STORE_ADDR_BITS;
    localparam int WRAP_BITS       = 16;

    // CGA interleave constants.
    localparam logic [WRAP_BITS-1:0] ODD_BANK       = 16'h2000;
    localparam logic [WRAP_BITS-1:0] BANK_ROW_BYTES = 16'd80;
    localparam logic [7:0]           XOR_FLAG       = 8'h80;
    localparam logic [7:0]           FIELD_2BPP     = 8'h03;
    localparam logic [7:0]           FIELD_1BPP     = 8'h01;

    // Video mode codes.
    localparam logic [1:0] MODE_CGA2   = 2'd0;
    localparam logic [1:0] MODE_CGA1   = 2'd1;
    localparam logic [1:0] MODE_LINEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VIDEO_MODE   = 2'd0;
    localparam logic [1:0] CFG_TEXT_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_PAGE_BYTES   = 2'd2;

    // Request command codes.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Memory access request from the control logic to the store.
    typedef struct packed {
        logic                       rd_en;
        logic [STORE_ADDR_BITS-1:0] rd_addr;
        logic                       wr_en;
        logic [STORE_ADDR_BITS-1:0] wr_addr;
        logic [7:0]                 wr_data;
    } store_req_t;

    // Map a wrapped 16-bit address onto the store, modulo its depth.
    function automatic logic [STORE_ADDR_BITS-1:0] store_index(
        input logic [WRAP_BITS-1:0] addr
    );
        logic [STORE_ADDR_BITS+WRAP_BITS-1:0] ext;
        ext = {{STORE_ADDR_BITS{1'b0}}, addr};
        return ext[STORE_ADDR_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clpa_addr_gen.sv =====
// Byte address generator: products registered in the first stage, final sum formed combinationally from them.
// Depends on clpa_pkg for geometry and mode codes.
`default_nettype none

module clpa_addr_gen (
    input  wire logic                                aclk,
    input  wire logic                                load,
    input  wire logic [9:0]                          pos_x,
    input  wire logic [9:0]                          pos_y,
    input  wire logic [2:0]                          page_num,
    input  wire logic [1:0]                          video_mode,
    input  wire logic [7:0]                          text_columns,
    input  wire logic [15:0]                         page_bytes,
    output logic [clpa_pkg::STORE_ADDR_BITS-1:0]     store_addr
);

    logic [9:0]                       x_reg;
    logic [clpa_pkg::WRAP_BITS-1:0]   lin_row_reg;
    logic [clpa_pkg::WRAP_BITS-1:0]   lin_page_reg;
    logic [clpa_pkg::WRAP_BITS-1:0]   cga_row_reg;

    logic [17:0]                      row_prod;
    logic [18:0]                      page_prod;
    logic [clpa_pkg::WRAP_BITS-1:0]   cga_row_next;
    logic [clpa_pkg::WRAP_BITS-1:0]   lin_addr;
    logic [clpa_pkg::WRAP_BITS-1:0]   cga_addr;
    logic [clpa_pkg::WRAP_BITS-1:0]   x_bytes;

    // First stage: one multiplier each for the linear row stride, the page offset and the CGA row.
    always_comb begin
        row_prod     = 18'(pos_y) * 18'(text_columns);
        page_prod    = 19'(page_num) * 19'(page_bytes);
        cga_row_next = 16'(pos_y[9:1]) * clpa_pkg::BANK_ROW_BYTES;
        if (pos_y[0]) begin
            cga_row_next = cga_row_next + clpa_pkg::ODD_BANK;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg        <= pos_x;
            lin_row_reg  <= {row_prod[12:0], 3'b000};
            lin_page_reg <= page_prod[15:0];
            cga_row_reg  <= cga_row_next;
        end
    end

    // Second stage: sum the terms, wrapping at 16 bits.
    always_comb begin
        lin_addr = 16'(x_reg) + lin_row_reg + lin_page_reg;
        if (video_mode == clpa_pkg::MODE_CGA2) begin
            x_bytes = 16'(x_reg[9:2]);
        end else begin
            x_bytes = 16'(x_reg[9:3]);
        end
        cga_addr = cga_row_reg + x_bytes;
        if (video_mode == clpa_pkg::MODE_LINEAR) begin
            store_addr = clpa_pkg::store_index(lin_addr);
        end else begin
            store_addr = clpa_pkg::store_index(cga_addr);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/clpa_store.sv =====
// Byte-wide video store: one synchronous read port, one write port, clearing pass after reset.
// Depends on clpa_pkg for the store geometry and the request struct.
`default_nettype none

module clpa_store (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire clpa_pkg::store_req_t  req,
    output logic [7:0]                 rd_data,
    output logic                       clr_busy
);

    logic [7:0] mem [0:clpa_pkg::STORE_DEPTH-1];

    logic [7:0]                           rd_data_reg;
    logic                                 clr_busy_reg;
    logic [clpa_pkg::STORE_ADDR_BITS-1:0] clr_addr_reg;

    logic                                 wr_en;
    logic [clpa_pkg::STORE_ADDR_BITS-1:0] wr_addr;
    logic [7:0]                           wr_data;

    // The clearing pass owns the write port until every entry holds zero.
    always_comb begin
        if (clr_busy_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 8'h00;
        end else begin
            wr_en   = req.wr_en;
            wr_addr = req.wr_addr;
            wr_data = req.wr_data;
        end
    end

    // Clearing sweep, one entry per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Memory array with registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cga_linear_pixel_access.sv =====
// Top level of the CGA and linear pixel access unit: ports, configuration and control.
// Depends on clpa_pkg, clpa_addr_gen and clpa_store.
//
//  Channel   Direction  Ports                          Contents
//  s_        in         s_tvalid s_tready s_tdata      one pixel request
//                       s_tuser
//  m_        out        m_tvalid m_tready m_tdata      pixel value of a read
//  cfg_      in         cfg_valid cfg_ready cfg_index  register write
//                       cfg_data
//
// Each request passes in turn through acceptance with the address products, the address sum
// with the store read, then the modify and write-back or the result load; the store's
// single read-then-write per request sets this order; no request is accepted meanwhile.
// After reset a clearing pass zeroes every entry of the store; no request is accepted
// meanwhile, though register writes are taken.
// A read whose result finds the output register still full waits in its last cycle.
`default_nettype none

module cga_linear_pixel_access (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // pos_x[9:0], pos_y[19:10], page_num[22:20],
                                        // color[30:23], zero[31]
    input  wire logic [0:0]  s_tuser,   // cmd[0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // pixel_value[7:0]

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DATA
    } state_t;

    state_t     state_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    logic [1:0]  video_mode_reg;
    logic [7:0]  text_columns_reg;
    logic [15:0] page_bytes_reg;

    logic                                 cmd_reg;
    logic [7:0]                           color_reg;
    logic [2:0]                           x_lo_reg;
    logic [clpa_pkg::STORE_ADDR_BITS-1:0] addr_reg;

    logic                                 s_accept;
    logic                                 clr_busy;
    logic [clpa_pkg::STORE_ADDR_BITS-1:0] gen_addr;
    logic [7:0]                           rd_data;
    clpa_pkg::store_req_t                 st_req;

    logic       cga_mode;
    logic [2:0] shift;
    logic [7:0] field;
    logic [7:0] bits;
    logic [7:0] cga_new;
    logic [7:0] read_value;
    logic       out_free;
    logic       result_load;

    assign s_accept    = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE) && !clr_busy;
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign result_load = (state_reg == ST_DATA) && (cmd_reg == clpa_pkg::CMD_READ) && out_free;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            video_mode_reg   <= clpa_pkg::MODE_CGA2;
            text_columns_reg <= 8'd40;
            page_bytes_reg   <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                clpa_pkg::CFG_VIDEO_MODE:   video_mode_reg   <= cfg_data[1:0];
                clpa_pkg::CFG_TEXT_COLUMNS: text_columns_reg <= cfg_data[7:0];
                clpa_pkg::CFG_PAGE_BYTES:   page_bytes_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request fields kept for the modify stage.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_tuser[0];
            color_reg <= s_tdata[30:23];
            x_lo_reg  <= s_tdata[2:0];
        end
        if (state_reg == ST_ADDR) begin
            addr_reg <= gen_addr;
        end
    end

    clpa_addr_gen u_addr_gen (
        .aclk         (aclk),
        .load         (s_accept),
        .pos_x        (s_tdata[9:0]),
        .pos_y        (s_tdata[19:10]),
        .page_num     (s_tdata[22:20]),
        .video_mode   (video_mode_reg),
        .text_columns (text_columns_reg),
        .page_bytes   (page_bytes_reg),
        .store_addr   (gen_addr)
    );

    // Pixel field extraction and merge for the CGA modes, and the read value for every mode.
    always_comb begin
        cga_mode = (video_mode_reg == clpa_pkg::MODE_CGA2) ||
                   (video_mode_reg == clpa_pkg::MODE_CGA1);
        if (video_mode_reg == clpa_pkg::MODE_CGA2) begin
            shift = {~x_lo_reg[1], ~x_lo_reg[0], 1'b0};
            field = clpa_pkg::FIELD_2BPP;
        end else begin
            shift = ~x_lo_reg;
            field = clpa_pkg::FIELD_1BPP;
        end
        bits = (color_reg & field) << shift;
        if ((color_reg & clpa_pkg::XOR_FLAG) != 8'h00) begin
            cga_new = rd_data ^ bits;
        end else begin
            cga_new = (rd_data & ~(field << shift)) | bits;
        end
        if (cga_mode) begin
            read_value = (rd_data >> shift) & field;
        end else if (video_mode_reg == clpa_pkg::MODE_LINEAR) begin
            read_value = rd_data;
        end else begin
            read_value = 8'h00;
        end
    end

    // Store requests: read in the address cycle, write back in the data cycle.
    always_comb begin
        st_req.rd_en   = (state_reg == ST_ADDR);
        st_req.rd_addr = gen_addr;
        st_req.wr_en   = (state_reg == ST_DATA) && (cmd_reg == clpa_pkg::CMD_WRITE) &&
                         (cga_mode || (video_mode_reg == clpa_pkg::MODE_LINEAR));
        st_req.wr_addr = addr_reg;
        st_req.wr_data = cga_mode ? cga_new : color_reg;
    end

    clpa_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (st_req),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    // Request sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    state_reg <= ST_DATA;
                end
                ST_DATA: begin
                    if (cmd_reg == clpa_pkg::CMD_WRITE) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_tdata_reg <= read_value;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // An accepted request always moves on to the address cycle.
    a_accept_to_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_ADDR)
        else $error("accepted request did not enter the address cycle");

    // A result appears only at the end of a read request.
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DATA) &&
                            $past(cmd_reg == clpa_pkg::CMD_READ))
        else $error("result raised without a finished read");

    // Store writes from the control side happen only in the data cycle, never while clearing.
    a_write_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        st_req.wr_en |-> (state_reg == ST_DATA) && !clr_busy)
        else $error("store write outside the data cycle");

    // A waiting result is not overwritten by the next read.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pending result lost or changed");

endmodule

`default_nettype wire

// ===== sim/cga_linear_pixel_access_tb.sv =====
// Self-checking testbench for the CGA and linear pixel access unit: pixel requests are driven
// on the stream input, read results are checked against a shadow copy of the video store.
// Depends on clpa_pkg and the cga_linear_pixel_access RTL.
`timescale 1ns / 1ps

module cga_linear_pixel_access_tb;

    // Mode 3 has no name in the package; the block ignores writes and reads back zero.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Cycles to let pass after the last result, enough for a write still in the pipeline.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RECENT_DEPTH  = 16;

    typedef struct packed {
        logic       cmd;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
        logic [2:0] page_num;
        logic [7:0] color;
    } pixel_req_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Shadow of the block's store and registers.
    logic [7:0]  pixel_store [0:clpa_pkg::STORE_DEPTH-1];
    logic [1:0]  video_mode;
    logic [7:0]  text_columns;
    logic [15:0] page_bytes;

    logic [7:0]  pending_pixels [$];
    pixel_req_t  recent_pixels [$];
    int          mismatch_count = 0;
    bit          gaps_on = 1'b1;
    int          stall_request = 0;

    cga_linear_pixel_access dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one accepted request to the shadow store and queue the pixel a read returns.
    task automatic predict_pixel_access(input pixel_req_t r);
        logic [15:0]  addr;
        logic [7:0]   data;
        logic [7:0]   fmask;
        logic [7:0]   bits;
        int unsigned  lin;
        int           shift;
        case (video_mode)
            clpa_pkg::MODE_CGA2, clpa_pkg::MODE_CGA1: begin
                if (video_mode == clpa_pkg::MODE_CGA2) begin
                    shift = (3 - r.pos_x[1:0]) * 2;
                    fmask = clpa_pkg::FIELD_2BPP;
                    addr  = 16'(r.pos_x >> 2);
                end else begin
                    shift = 7 - r.pos_x[2:0];
                    fmask = clpa_pkg::FIELD_1BPP;
                    addr  = 16'(r.pos_x >> 3);
                end
                addr = addr + 16'(r.pos_y >> 1) * clpa_pkg::BANK_ROW_BYTES;
                if (r.pos_y[0]) begin
                    addr = addr + clpa_pkg::ODD_BANK;
                end
                data = pixel_store[addr];
                if (r.cmd == clpa_pkg::CMD_WRITE) begin
                    bits = (r.color & fmask) << shift;
                    if ((r.color & clpa_pkg::XOR_FLAG) != 8'd0) begin
                        data = data ^ bits;
                    end else begin
                        data = (data & ~(fmask << shift)) | bits;
                    end
                    pixel_store[addr] = data;
                end else begin
                    pending_pixels.push_back((data >> shift) & fmask);
                end
            end
            clpa_pkg::MODE_LINEAR: begin
                lin  = 32'(r.pos_x) + 32'(r.pos_y) * (32'(text_columns) * 32'd8)
                     + 32'(r.page_num) * 32'(page_bytes);
                addr = lin[15:0];
                if (r.cmd == clpa_pkg::CMD_WRITE) begin
                    pixel_store[addr] = r.color;
                end else begin
                    pending_pixels.push_back(pixel_store[addr]);
                end
            end
            default: begin
                if (r.cmd == clpa_pkg::CMD_READ) begin
                    pending_pixels.push_back(8'd0);
                end
            end
        endcase
    endtask

    // Offer one request and hold it until accepted, then perhaps leave a gap.
    // Called at a rising edge; returns at a rising edge.
    task automatic send_pixel_request(input pixel_req_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.color, r.page_num, r.pos_y, r.pos_x};
        s_tuser  <= r.cmd;
        do @(posedge aclk); while (!s_tready);
        predict_pixel_access(r);
        recent_pixels.push_back(r);
        if (recent_pixels.size() > RECENT_DEPTH) begin
            void'(recent_pixels.pop_front());
        end
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic release_sender();
        s_tvalid <= 1'b0;
    endtask

    task automatic send_pixel(input logic cmd, input int x, input int y, input int page,
                              input int color);
        pixel_req_t r;
        r.cmd      = cmd;
        r.pos_x    = x[9:0];
        r.pos_y    = y[9:0];
        r.page_num = page[2:0];
        r.color    = color[7:0];
        send_pixel_request(r);
    endtask

    // Wait until every expected pixel has come or DRAIN_LIMIT is reached, then let the pipeline empty.
    task automatic wait_for_results();
        int n;
        n = 0;
        while (pending_pixels.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            clpa_pkg::CFG_VIDEO_MODE:   video_mode   = value[1:0];
            clpa_pkg::CFG_TEXT_COLUMNS: text_columns = value[7:0];
            clpa_pkg::CFG_PAGE_BYTES:   page_bytes   = value;
            default: ;
        endcase
    endtask

    task automatic set_video_config(input logic [1:0] mode, input logic [7:0] cols,
                                    input logic [15:0] pbytes);
        write_register(clpa_pkg::CFG_VIDEO_MODE, {14'd0, mode});
        write_register(clpa_pkg::CFG_TEXT_COLUMNS, {8'd0, cols});
        write_register(clpa_pkg::CFG_PAGE_BYTES, pbytes);
        cfg_valid <= 1'b0;
    endtask

    // A random request, half the time near a recently used pixel so reads find written data.
    function automatic pixel_req_t random_request();
        pixel_req_t r;
        pixel_req_t near;
        r.cmd   = $urandom_range(0, 1) ? clpa_pkg::CMD_WRITE : clpa_pkg::CMD_READ;
        r.color = 8'($urandom_range(0, 255));
        if (recent_pixels.size() != 0 && $urandom_range(0, 1) == 1) begin
            near       = recent_pixels[$urandom_range(0, recent_pixels.size() - 1)];
            r.pos_x    = near.pos_x ^ 10'($urandom_range(0, 7));
            r.pos_y    = near.pos_y;
            r.page_num = near.page_num;
        end else begin
            r.pos_x    = 10'($urandom_range(0, 1023));
            r.pos_y    = 10'($urandom_range(0, 1023));
            r.page_num = 3'($urandom_range(0, 7));
        end
        return r;
    endfunction

    task automatic random_config();
        logic [1:0]  mode;
        logic [7:0]  cols;
        logic [15:0] pbytes;
        case ($urandom_range(0, 9))
            0, 1, 2: mode = clpa_pkg::MODE_CGA2;
            3, 4, 5: mode = clpa_pkg::MODE_CGA1;
            6, 7, 8: mode = clpa_pkg::MODE_LINEAR;
            default: mode = MODE_UNUSED;
        endcase
        case ($urandom_range(0, 5))
            0:       cols = 8'd1;
            1:       cols = 8'd255;
            2:       cols = 8'd0;
            default: cols = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 4))
            0:       pbytes = 16'd0;
            1:       pbytes = 16'hFFFF;
            default: pbytes = 16'($urandom_range(0, 65535));
        endcase
        set_video_config(mode, cols, pbytes);
    endtask

    // Two-bit CGA: replace, XOR, both banks and the far corner.
    task automatic test_cga2_directed();
        set_video_config(clpa_pkg::MODE_CGA2, 8'd40, 16'd0);
        send_pixel(clpa_pkg::CMD_READ, 0, 0, 0, 0);
        send_pixel(clpa_pkg::CMD_WRITE, 0, 0, 7, 8'h03);
        send_pixel(clpa_pkg::CMD_WRITE, 1, 0, 0, 8'h02);
        send_pixel(clpa_pkg::CMD_WRITE, 3, 0, 0, 8'h7D);
        send_pixel(clpa_pkg::CMD_READ, 0, 0, 0, 0);
        send_pixel(clpa_pkg::CMD_READ, 1, 0, 0, 0);
        send_pixel(clpa_pkg::CMD_READ, 3, 0, 0, 0);
        send_pixel(clpa_pkg::CMD_WRITE, 1, 0, 0, 8'h83);
        send_pixel(clpa_pkg::CMD_READ, 1, 0, 0, 0);
        send_pixel(clpa_pkg::CMD_WRITE, 1023, 1023, 0, 8'hFE);
        send_pixel(clpa_pkg::CMD_READ, 1023, 1023, 7, 8'hFF);
        release_sender();
        wait_for_results();
    endtask

    // One-bit CGA: replace then XOR back to zero in the odd bank, and the even-bank far corner.
    task automatic test_cga1_directed();
        set_video_config(clpa_pkg::MODE_CGA1, 8'd40, 16'd0);
        send_pixel(clpa_pkg::CMD_WRITE, 7, 1, 0, 8'h01);
        send_pixel(clpa_pkg::CMD_WRITE, 7, 1, 0, 8'h81);
        send_pixel(clpa_pkg::CMD_READ, 7, 1, 0, 0);
        send_pixel(clpa_pkg::CMD_WRITE, 1023, 1022, 0, 8'hFF);
        send_pixel(clpa_pkg::CMD_READ, 1023, 1022, 0, 0);
        release_sender();
        wait_for_results();
    endtask

    // Linear mode: widest stride and page with 16-bit wrap, bit 7 stored as plain data.
    task automatic test_linear_directed();
        set_video_config(clpa_pkg::MODE_LINEAR, 8'd255, 16'hFFFF);
        send_pixel(clpa_pkg::CMD_WRITE, 1023, 1023, 7, 8'h80);
        send_pixel(clpa_pkg::CMD_READ, 1023, 1023, 7, 0);
        release_sender();
        wait_for_results();
        set_video_config(clpa_pkg::MODE_LINEAR, 8'd1, 16'd0);
        send_pixel(clpa_pkg::CMD_WRITE, 5, 3, 7, 8'hFF);
        send_pixel(clpa_pkg::CMD_READ, 5, 3, 0, 0);
        release_sender();
        wait_for_results();
    endtask

    // The unused mode ignores a write and reads back zero; linear mode then sees no change.
    task automatic test_unused_mode();
        set_video_config(MODE_UNUSED, 8'd1, 16'd0);
        send_pixel(clpa_pkg::CMD_WRITE, 5, 3, 0, 8'h5A);
        send_pixel(clpa_pkg::CMD_READ, 5, 3, 0, 0);
        release_sender();
        wait_for_results();
        set_video_config(clpa_pkg::MODE_LINEAR, 8'd1, 16'd0);
        send_pixel(clpa_pkg::CMD_READ, 5, 3, 0, 0);
        release_sender();
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while reads keep coming, so the block stalls.
    task automatic test_output_backpressure();
        pixel_req_t r;
        set_video_config(clpa_pkg::MODE_CGA2, 8'd40, 16'd0);
        gaps_on = 1'b0;
        stall_request = 400;
        for (int i = 0; i < 40; i++) begin
            r = random_request();
            if (i % 4 != 0) begin
                r.cmd = clpa_pkg::CMD_READ;
            end
            send_pixel_request(r);
        end
        release_sender();
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    // The sender stops mid-stream until every result is back, then carries on.
    task automatic test_sender_pause();
        random_config();
        for (int i = 0; i < 30; i++) begin
            send_pixel_request(random_request());
        end
        release_sender();
        wait_for_results();
        for (int i = 0; i < 30; i++) begin
            send_pixel_request(random_request());
        end
        release_sender();
        wait_for_results();
    endtask

    // Random phases, each under a fresh register setting.
    task automatic test_random_phases(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            random_config();
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < per_phase; i++) begin
                send_pixel_request(random_request());
            end
            release_sender();
            wait_for_results();
        end
        gaps_on = 1'b1;
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_full_rate();
        gaps_on = 1'b0;
        set_video_config(clpa_pkg::MODE_CGA1, 8'd40, 16'd0);
        for (int i = 0; i < 45; i++) begin
            send_pixel_request(random_request());
        end
        release_sender();
        wait_for_results();
        set_video_config(clpa_pkg::MODE_LINEAR, 8'd80, 16'h4000);
        for (int i = 0; i < 45; i++) begin
            send_pixel_request(random_request());
        end
        release_sender();
        wait_for_results();
    endtask

    // Receiver: random stalls, or a long counted hold-off when one is requested.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_request > 0) begin
                m_tready <= 1'b0;
                repeat (stall_request) @(posedge aclk);
                stall_request = 0;
                m_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each returned pixel with the oldest expectation.
    always @(posedge aclk) begin : check_pixels
        logic [7:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel_value: expected none, got %02h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata !== want) begin
                    $error("pixel_value: expected %02h, got %02h", want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 32'd0;
        s_tuser   <= clpa_pkg::CMD_READ;
        cfg_valid <= 1'b0;
        cfg_index <= clpa_pkg::CFG_VIDEO_MODE;
        cfg_data  <= 16'd0;
        for (int i = 0; i < clpa_pkg::STORE_DEPTH; i++) begin
            pixel_store[i] = 8'd0;
        end
        video_mode   = clpa_pkg::MODE_CGA2;
        text_columns = 8'd40;
        page_bytes   = 16'd0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_cga2_directed();
        test_cga1_directed();
        test_linear_directed();
        test_unused_mode();
        test_output_backpressure();
        test_sender_pause();
        test_random_phases(8, 95);
        test_full_rate();

        if (pending_pixels.size() != 0) begin
            $error("pixel_value: %0d expected results never arrived", pending_pixels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== cga_linear_pixel_access.f =====
rtl/core/clpa_pkg.sv
rtl/core/clpa_addr_gen.sv
rtl/core/clpa_store.sv
rtl/core/cga_linear_pixel_access.sv
sim/cga_linear_pixel_access_tb.sv
